// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/dlps_pkg.sv =====
// Shared types and constants for the delay line pitch shifter.
package dlps_pkg;

    localparam int STEP_BITS = 19;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_TAP,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_RD4,
        ST_MIX0,
        ST_MIX1,
        ST_MIX2,
        ST_MIX3,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_LEAD_A,
        RD_LEAD_B,
        RD_LAG_A,
        RD_LAG_B
    } rd_sel_t;

    typedef enum logic [1:0] {
        MUL_MEM,
        MUL_S0,
        MUL_S1
    } mul_src_t;

    typedef enum logic [2:0] {
        COEF_LEAD_INV,
        COEF_LEAD,
        COEF_LAG_INV,
        COEF_LAG,
        COEF_W_INV,
        COEF_W
    } coef_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic      in_load;
        logic      mem_we;
        logic      commit_start;
        logic      tap_load;
        rd_sel_t   rd_sel;
        logic      prod_en;
        mul_src_t  mul_src;
        coef_sel_t coef_sel;
        acc_op_t   acc_op;
        logic      s0_load;
        logic      s1_load;
        logic      out_load;
        logic      out_bypass;
        logic      advance;
    } dp_cmd_t;

    typedef struct packed {
        logic bypass;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/dlps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dlps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/dlps_ctrl.sv =====
// Sequencer: walks one sample through write, four tap reads and the mixes; a bypassed sample goes from write to done.
module dlps_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  dlps_pkg::dp_status_t   status,
    output dlps_pkg::dp_cmd_t      cmd
);

    import dlps_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: state_next = status.bypass ? ST_DONE : ST_TAP;
            ST_TAP:   state_next = ST_RD0;
            ST_RD0:   state_next = ST_RD1;
            ST_RD1:   state_next = ST_RD2;
            ST_RD2:   state_next = ST_RD3;
            ST_RD3:   state_next = ST_RD4;
            ST_RD4:   state_next = ST_MIX0;
            ST_MIX0:  state_next = ST_MIX1;
            ST_MIX1:  state_next = ST_MIX2;
            ST_MIX2:  state_next = ST_MIX3;
            ST_MIX3:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Read data is registered in the store, so each multiply comes in the
    // state after its read.
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.in_load = s_tvalid;
            end
            ST_WRITE:
            begin
                cmd.mem_we       = !status.bypass;
                cmd.commit_start = !status.bypass;
            end
            ST_TAP:
            begin
                cmd.tap_load = 1'b1;
            end
            ST_RD0:
            begin
                cmd.rd_sel = RD_LEAD_A;
            end
            ST_RD1:
            begin
                cmd.rd_sel   = RD_LEAD_B;
                cmd.prod_en  = 1'b1;
                cmd.mul_src  = MUL_MEM;
                cmd.coef_sel = COEF_LEAD_INV;
            end
            ST_RD2:
            begin
                cmd.rd_sel   = RD_LAG_A;
                cmd.prod_en  = 1'b1;
                cmd.mul_src  = MUL_MEM;
                cmd.coef_sel = COEF_LEAD;
                cmd.acc_op   = ACC_LOAD;
            end
            ST_RD3:
            begin
                cmd.rd_sel   = RD_LAG_B;
                cmd.prod_en  = 1'b1;
                cmd.mul_src  = MUL_MEM;
                cmd.coef_sel = COEF_LAG_INV;
                cmd.acc_op   = ACC_ADD;
            end
            ST_RD4:
            begin
                cmd.prod_en  = 1'b1;
                cmd.mul_src  = MUL_MEM;
                cmd.coef_sel = COEF_LAG;
                cmd.acc_op   = ACC_LOAD;
                cmd.s0_load  = 1'b1;
            end
            ST_MIX0:
            begin
                cmd.prod_en  = 1'b1;
                cmd.mul_src  = MUL_S0;
                cmd.coef_sel = COEF_W_INV;
                cmd.acc_op   = ACC_ADD;
            end
            ST_MIX1:
            begin
                cmd.acc_op  = ACC_LOAD;
                cmd.s1_load = 1'b1;
            end
            ST_MIX2:
            begin
                cmd.prod_en  = 1'b1;
                cmd.mul_src  = MUL_S1;
                cmd.coef_sel = COEF_W;
            end
            ST_MIX3:
            begin
                cmd.acc_op = ACC_ADD;
            end
            ST_DONE:
            begin
                cmd.out_load   = status.out_free;
                cmd.out_bypass = status.bypass;
                cmd.advance    = status.out_free && !status.bypass;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/dlps_datapath.sv =====
// Datapath: delay store, tap pointers, shared multiply-accumulate, output beat.
module dlps_datapath #(
    parameter int DELAY_DEPTH     = 16384,
    parameter int SAMPLE_BITS     = 24,
    parameter int PHASE_FRAC_BITS = 16,
    parameter int TD_W            = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dlps_pkg::dp_cmd_t                 cmd,
    output dlps_pkg::dp_status_t              status,
    input  logic [TD_W-1:0]                   s_tdata,
    input  logic                              s_tuser,
    input  logic                              cfg_valid,
    input  logic [dlps_pkg::STEP_BITS-1:0]    cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [TD_W-1:0]                   m_tdata
);

    import dlps_pkg::*;

    // Depth must be a power of two, which the block does not check, so phase wrap is plain truncation.
    localparam int ADDR_W = $clog2(DELAY_DEPTH);
    localparam int FRAC_W = PHASE_FRAC_BITS;
    localparam int PH_W   = ADDR_W + FRAC_W;
    localparam int SUM_W  = ((PH_W > STEP_BITS) ? PH_W : STEP_BITS) + 1;
    localparam int PROD_W = SAMPLE_BITS + FRAC_W + 2;
    localparam int ACC_W  = PROD_W + 1;

    localparam logic [FRAC_W:0]  FRAC_ONE  = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [PH_W-1:0]  LAG_START = {1'b1, {(PH_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] RND_HALF =
        ACC_W'(64'sd1 <<< (FRAC_W - 1));
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    // control state
    logic signed [STEP_BITS-1:0] step_reg, step_next;
    logic [ADDR_W-1:0]           wp_reg, wp_next;
    logic [ADDR_W:0]             fill_reg, fill_next;
    logic [PH_W-1:0]             lead_reg, lead_next;
    logic [PH_W-1:0]             lag_reg, lag_next;
    logic                        out_valid_reg, out_valid_next;

    // payload
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic                          bs_reg, bs_next;
    logic [ADDR_W-1:0]             lead_idx_reg, lead_idx_next;
    logic [ADDR_W-1:0]             lag_idx_reg, lag_idx_next;
    logic [FRAC_W-1:0]             lead_frac_reg, lead_frac_next;
    logic [FRAC_W-1:0]             lag_frac_reg, lag_frac_next;
    logic                          rd_ok_reg, rd_ok_next;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic signed [SAMPLE_BITS-1:0] s0_reg, s0_next;
    logic signed [SAMPLE_BITS-1:0] s1_reg, s1_next;
    logic [SAMPLE_BITS-1:0]        out_reg, out_next;

    // working signals
    logic [ADDR_W-1:0]             wp_eff;
    logic [PH_W-1:0]               lead_eff, lag_eff;
    logic [PH_W-1:0]               lead_tap, lag_tap;
    logic [ADDR_W-1:0]             rd_addr;
    logic [SAMPLE_BITS-1:0]        ram_q;
    logic signed [SAMPLE_BITS-1:0] mem_q;
    logic signed [SAMPLE_BITS-1:0] mul_a;
    logic [FRAC_W:0]               coef;
    logic [FRAC_W-1:0]             xfade_w;
    logic signed [ACC_W-1:0]       rnd_sum, rnd_val;
    logic signed [SAMPLE_BITS-1:0] sat_val;
    logic [SUM_W-1:0]              lead_sum, lag_sum;

    dlps_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DELAY_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.mem_we),
        .waddr (wp_eff),
        .wdata (x_reg),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // block start restarts pointer and phases ahead of this sample
    assign wp_eff   = bs_reg ? '0 : wp_reg;
    assign lead_eff = bs_reg ? '0 : lead_reg;
    assign lag_eff  = bs_reg ? LAG_START : lag_reg;

    assign lead_tap = {wp_reg, {FRAC_W{1'b0}}} - lead_reg;
    assign lag_tap  = {wp_reg, {FRAC_W{1'b0}}} - lag_reg;
    assign xfade_w  = lead_reg[PH_W-1:ADDR_W];

    always_comb
    begin
        case (cmd.rd_sel)
            RD_LEAD_A: rd_addr = lead_idx_reg;
            RD_LEAD_B: rd_addr = lead_idx_reg + ADDR_W'(1);
            RD_LAG_A:  rd_addr = lag_idx_reg;
            RD_LAG_B:  rd_addr = lag_idx_reg + ADDR_W'(1);
            default:   rd_addr = lead_idx_reg;
        endcase
    end

    // entries at or above the fill mark were never written and read as zero
    assign mem_q = rd_ok_reg ? $signed(ram_q) : '0;

    always_comb
    begin
        case (cmd.mul_src)
            MUL_MEM: mul_a = mem_q;
            MUL_S0:  mul_a = s0_reg;
            MUL_S1:  mul_a = s1_reg;
            default: mul_a = mem_q;
        endcase
    end

    always_comb
    begin
        case (cmd.coef_sel)
            COEF_LEAD_INV: coef = FRAC_ONE - {1'b0, lead_frac_reg};
            COEF_LEAD:     coef = {1'b0, lead_frac_reg};
            COEF_LAG_INV:  coef = FRAC_ONE - {1'b0, lag_frac_reg};
            COEF_LAG:      coef = {1'b0, lag_frac_reg};
            COEF_W_INV:    coef = FRAC_ONE - {1'b0, xfade_w};
            COEF_W:        coef = {1'b0, xfade_w};
            default:       coef = '0;
        endcase
    end

    // round to nearest, ties up
    assign rnd_sum = acc_reg + RND_HALF;
    assign rnd_val = rnd_sum >>> FRAC_W;

    always_comb
    begin
        if (rnd_val > SAT_MAX)
        begin
            sat_val = SAT_MAX[SAMPLE_BITS-1:0];
        end
        else if (rnd_val < SAT_MIN)
        begin
            sat_val = SAT_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat_val = rnd_val[SAMPLE_BITS-1:0];
        end
    end

    assign lead_sum = SUM_W'(lead_reg) + SUM_W'(step_reg);
    assign lag_sum  = SUM_W'(lag_reg) + SUM_W'(step_reg);

    always_comb
    begin
        step_next      = step_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        lead_next      = lead_reg;
        lag_next       = lag_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        bs_next        = bs_reg;
        lead_idx_next  = lead_idx_reg;
        lag_idx_next   = lag_idx_reg;
        lead_frac_next = lead_frac_reg;
        lag_frac_next  = lag_frac_reg;
        rd_ok_next     = ({1'b0, rd_addr} < fill_reg);
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        out_next       = out_reg;

        if (cfg_valid)
        begin
            step_next = $signed(cfg_data);
        end
        if (cmd.in_load)
        begin
            x_next  = $signed(s_tdata[SAMPLE_BITS-1:0]);
            bs_next = s_tuser;
        end
        if (cmd.commit_start)
        begin
            wp_next   = wp_eff;
            lead_next = lead_eff;
            lag_next  = lag_eff;
            if (({1'b0, wp_eff} + (ADDR_W+1)'(1)) > fill_reg)
            begin
                fill_next = {1'b0, wp_eff} + (ADDR_W+1)'(1);
            end
        end
        if (cmd.tap_load)
        begin
            lead_idx_next  = lead_tap[PH_W-1:FRAC_W];
            lead_frac_next = lead_tap[FRAC_W-1:0];
            lag_idx_next   = lag_tap[PH_W-1:FRAC_W];
            lag_frac_next  = lag_tap[FRAC_W-1:0];
        end
        if (cmd.prod_en)
        begin
            prod_next = PROD_W'(mul_a) * PROD_W'($signed({1'b0, coef}));
        end
        case (cmd.acc_op)
            ACC_LOAD: acc_next = ACC_W'(prod_reg);
            ACC_ADD:  acc_next = acc_reg + ACC_W'(prod_reg);
            default:  acc_next = acc_reg;
        endcase
        if (cmd.s0_load)
        begin
            s0_next = rnd_val[SAMPLE_BITS-1:0];
        end
        if (cmd.s1_load)
        begin
            s1_next = rnd_val[SAMPLE_BITS-1:0];
        end
        if (cmd.advance)
        begin
            lead_next = lead_sum[PH_W-1:0];
            lag_next  = lag_sum[PH_W-1:0];
            wp_next   = wp_reg + ADDR_W'(1);
        end
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_next       = cmd.out_bypass ? x_reg : sat_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            lead_reg      <= '0;
            lag_reg       <= LAG_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            lead_reg      <= lead_next;
            lag_reg       <= lag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        bs_reg        <= bs_next;
        lead_idx_reg  <= lead_idx_next;
        lag_idx_reg   <= lag_idx_next;
        lead_frac_reg <= lead_frac_next;
        lag_frac_reg  <= lag_frac_next;
        rd_ok_reg     <= rd_ok_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        s0_reg        <= s0_next;
        s1_reg        <= s1_next;
        out_reg       <= out_next;
    end

    assign status.bypass   = (step_reg == '0);
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TD_W'(out_reg);

endmodule

// ===== rtl/delay_line_pitch_shifter_unit.sv =====
// Top level of the dual-tap delay line pitch shifter.
//
// Input beats arrive on s_tvalid/s_tready: s_tdata carries the sample,
// s_tuser flags the first sample of a block (write pointer and tap
// phases restart, the delay store keeps its contents). Each input beat
// yields exactly one output beat on m_tvalid/m_tready.
// phase_step is written on cfg_valid/cfg_data; the user must write it
// only while the unit is idle, which the unit does not enforce. A step
// of zero passes samples straight through and changes no pointer,
// phase, fill mark or store state. One item at a time: a normal sample
// needs the four reads through the single store read port and the one
// shared multiply-accumulate that serves both tap interpolations and
// the crossfade before the next accept; a bypassed sample skips them.
// The output beat turns valid once the done state loads the output
// register; if the receiver stalls, the next sample is still accepted
// and waits before its last step until the register is free. Reset
// initialises pointers, phases, phase_step and the fill mark; store
// entries never written since reset read as zero, so no clearing pass.
module delay_line_pitch_shifter_unit #(
    parameter  int DELAY_DEPTH     = 16384,
    parameter  int SAMPLE_BITS     = 24,
    parameter  int PHASE_FRAC_BITS = 16,
    localparam int TD_W            = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [TD_W-1:0]                s_tdata,   // audio_in
    input  logic                           s_tuser,   // block_start
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [TD_W-1:0]                m_tdata,   // audio_out
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dlps_pkg::STEP_BITS-1:0] cfg_data
);

    import dlps_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    dlps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dlps_datapath #(
        .DELAY_DEPTH     (DELAY_DEPTH),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
        .TD_W            (TD_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== rtl/dlps_checker.sv =====
// Port-level checks for the pitch shifter, bound to the top level.
`include "assert_macros.svh"

module dlps_checker #(
    parameter int DATA_W = 24
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    // one sample in flight: busy right after an accept
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // a new result is only loaded at the end of a sample's work
    `ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(m_tvalid), $past(!s_tready))

endmodule

bind delay_line_pitch_shifter_unit dlps_checker #(
    .DATA_W (TD_W)
) u_dlps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
